// ===== rtl/assert_macros.svh =====
// Assertion helpers included by text_tokenizer_term_hash_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define TTH_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle check failed");

// Next-cycle implication, held off while reset is high.
`define TTH_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/tthash_pkg.sv =====
package tthash_pkg;

   // djb2 start value and multiplier shift (hash * 33 = (hash << 5) + hash)
   localparam logic [63:0] HashSeed  = 64'd5381;
   localparam int unsigned HashShift = 5;

   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7A;
   localparam logic [7:0] CaseOffset = 8'h20;

   // One result item
   typedef struct packed {
      logic        final_term;
      logic [31:0] term_position;
      logic [5:0]  term_length;
      logic [63:0] term_digest;
   } rsp_item_type;

   // Step outcome: whether an item is produced, and the item itself
   typedef struct packed {
      logic         emit;
      rsp_item_type item;
   } step_result_type;

   function automatic logic is_upper(input logic [7:0] b);
      is_upper = (b >= CharUpperA) && (b <= CharUpperZ);
   endfunction

   function automatic logic is_alnum(input logic [7:0] b);
      is_alnum = ((b >= CharZero) && (b <= CharNine)) || is_upper(b) ||
                 ((b >= CharLowerA) && (b <= CharLowerZ));
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      to_lower = is_upper(b) ? (b + CaseOffset) : b;
   endfunction

endpackage

// ===== rtl/tthash_step.sv =====
module tthash_step #(
   parameter int MAX_TERM_LEN = 64,
   parameter int LenW         = 6
) (
   input  logic [7:0]                  text_byte,
   input  logic                        end_of_text,
   input  logic [63:0]                 hash_cur,
   input  logic [LenW-1:0]             len_cur,
   input  logic [31:0]                 pos_cur,
   output logic [63:0]                 hash_next,
   output logic [LenW-1:0]             len_next,
   output logic [31:0]                 pos_next,
   output tthash_pkg::step_result_type result
);

   localparam int LenExtW = (LenW > 6) ? LenW : 6;
   localparam logic [LenW-1:0] LenLimit = LenW'(MAX_TERM_LEN - 1);

   logic                alnum;
   logic                grow;
   logic                sep_emit;
   logic [63:0]         hash_upd;
   logic [LenW-1:0]     len_upd;
   logic [LenExtW-1:0]  len_ext;

   // Fold the lower-cased character while the term still has room
   assign alnum    = tthash_pkg::is_alnum(text_byte);
   assign grow     = alnum && (len_cur < LenLimit);
   assign hash_upd = grow ? ((hash_cur << tthash_pkg::HashShift) + hash_cur +
                             {56'd0, tthash_pkg::to_lower(text_byte)})
                          : hash_cur;
   assign len_upd  = grow ? (len_cur + LenW'(1)) : len_cur;

   // A separator closes a pending term; so does the last byte of the text
   assign sep_emit = !alnum && (len_cur != '0);
   assign len_ext  = LenExtW'(len_upd);

   always_comb begin
      result.emit               = sep_emit || (end_of_text && alnum && (len_upd != '0));
      result.item.term_digest   = hash_upd;
      result.item.term_length   = len_ext[5:0];
      result.item.term_position = pos_cur;
      result.item.final_term    = end_of_text;
   end

   // Restart the term after an emission or at the end of the text
   always_comb begin
      if (end_of_text || sep_emit) begin
         hash_next = tthash_pkg::HashSeed;
         len_next  = '0;
      end else begin
         hash_next = hash_upd;
         len_next  = len_upd;
      end
      if (end_of_text) begin
         pos_next = '0;
      end else if (sep_emit) begin
         pos_next = pos_cur + 32'd1;
      end else begin
         pos_next = pos_cur;
      end
   end

endmodule

// ===== rtl/text_tokenizer_term_hash_core.sv =====
// Byte-stream tokenizer with djb2 term hashing.
// Input channel (req_): one text byte per item in req_tdata, req_tlast marks
// the last byte of a text. Letters and digits are lower-cased and hashed;
// any other byte separates terms. Result channel (rsp_): one item per closed
// term carrying its hash, kept length and word position; rsp_tlast is set
// when the term was closed by the last byte of the text.
// Timing: an item is registered at the input stage, then the hash step and
// term bookkeeping run combinationally into the result register, which
// drives rsp_tvalid. One byte is taken every cycle while the input stage is
// not held; the hash step is a 64-bit shift-and-add between the input
// register and the term state registers.
// Stall: when the result register is full and rsp_tready is low, the input
// stage holds only if its byte would produce a result; bytes that close no
// term keep flowing. req_tready falls once both stages are held.
// Reset: synchronous, active high; the hash restarts at 5381, length and
// position at zero, and both channels go empty.
`include "assert_macros.svh"

module text_tokenizer_term_hash_core #(
   parameter int MAX_TERM_LEN = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] text_byte
   input  logic         req_tlast,   // end_of_text
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [63:0] term_digest, [69:64] term_length,
                                     // [101:70] term_position, [103:102] zero
   output logic         rsp_tlast    // final_term
);

   localparam int LenW = $clog2(MAX_TERM_LEN);

   // Input stage
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // Term state
   logic [63:0]     hash_ff, hash_in;
   logic [LenW-1:0] len_ff, len_in;
   logic [31:0]     pos_ff, pos_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   tthash_pkg::rsp_item_type rsp_item_ff;

   tthash_pkg::step_result_type step_res;
   logic                        out_free;
   logic                        advance;

   tthash_step #(
      .MAX_TERM_LEN (MAX_TERM_LEN),
      .LenW         (LenW)
   ) u_step (
      .text_byte   (in_byte_ff),
      .end_of_text (in_last_ff),
      .hash_cur    (hash_ff),
      .len_cur     (len_ff),
      .pos_cur     (pos_ff),
      .hash_next   (hash_in),
      .len_next    (len_in),
      .pos_next    (pos_in),
      .result      (step_res)
   );

   // Advance the input stage unless its result has nowhere to go
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign advance     = in_valid_ff && (!step_res.emit || out_free);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture a new item whenever the stage is free
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Update the term state as each item leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= tthash_pkg::HashSeed;
         len_ff  <= '0;
         pos_ff  <= '0;
      end else if (advance) begin
         hash_ff <= hash_in;
         len_ff  <= len_in;
         pos_ff  <= pos_in;
      end
   end

   // Result register: load on emission, drop once taken
   always_comb begin
      if (advance && step_res.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_res.emit) begin
         rsp_item_ff <= step_res.item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_item_ff.term_position, rsp_item_ff.term_length,
                        rsp_item_ff.term_digest};
   assign rsp_tlast  = rsp_item_ff.final_term;

   // A held input item keeps its byte
   `TTH_ASSERT_NEXT(a_hold_input, clock, reset, in_valid_ff && !advance,
                    in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
   // The last byte of a text restarts the term state
   `TTH_ASSERT_NEXT(a_text_restart, clock, reset, advance && in_last_ff,
                    (pos_ff == '0) && (len_ff == '0) && (hash_ff == tthash_pkg::HashSeed))
   // Every emission lands in the result register
   `TTH_ASSERT_NEXT(a_emit_shown, clock, reset, advance && step_res.emit, rsp_valid_ff)

endmodule
